>>> hdl/assert_macros.svh
//------------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent checks written in the RTL.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/fcr_pkg.sv
//------------------------------------------------------------------------------
// fcr_pkg
// Codes and constants shared by the framed command receiver files.
//------------------------------------------------------------------------------
package fcr_pkg;

   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE          = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_BYTE            = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_TIME_SYNC      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_SET_PAGE       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_RESET_STEPS    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_REQUEST_STATUS = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_COUNT          = 3'd6;

   typedef logic [7:0]  byte_type;
   typedef logic [11:0] year_type;

   typedef enum logic [1:0] {
      ACK_OK          = 2'd0,
      ACK_BAD_LENGTH  = 2'd1,
      ACK_BAD_VALUE   = 2'd2,
      ACK_UNSUPPORTED = 2'd3
   } ack_status_type;

   typedef enum logic [2:0] {
      EV_NONE           = 3'd0,
      EV_TIME_SYNC      = 3'd1,
      EV_SET_PAGE       = 3'd2,
      EV_RESET_STEPS    = 3'd3,
      EV_REQUEST_STATUS = 3'd4
   } event_kind_type;

   localparam int unsigned FRAME_OVERHEAD = 5;
   localparam int unsigned TIME_SYNC_LEN  = 7;
   localparam int unsigned YEAR_BASE      = 2000;

endpackage

>>> hdl/fcr_req_if.sv
//------------------------------------------------------------------------------
// fcr_req_if
// Received byte channel with valid/ready handshake.
//------------------------------------------------------------------------------
interface fcr_req_if;
   import fcr_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hdl/fcr_rsp_if.sv
//------------------------------------------------------------------------------
// fcr_rsp_if
// Acknowledge channel with valid/ready handshake.
//------------------------------------------------------------------------------
interface fcr_rsp_if;
   import fcr_pkg::*;

   logic       valid;
   logic       ready;
   byte_type   ack_command;
   logic [1:0] ack_status;
   logic [2:0] event_kind;
   byte_type   hour;
   byte_type   minute;
   byte_type   second;
   year_type   year;
   byte_type   month;
   byte_type   day;
   byte_type   weekday;
   byte_type   page;

   modport source (
      output valid, output ack_command, output ack_status, output event_kind,
      output hour, output minute, output second, output year, output month,
      output day, output weekday, output page, input ready
   );
   modport sink (
      input valid, input ack_command, input ack_status, input event_kind,
      input hour, input minute, input second, input year, input month,
      input day, input weekday, input page, output ready
   );
endinterface

>>> hdl/framed_command_receiver.sv
//------------------------------------------------------------------------------
// framed_command_receiver
// Parses start/command/length/payload/checksum/end frames from a byte stream.
//------------------------------------------------------------------------------
// Bytes enter on the req channel, one beat per byte, and one byte can be taken
// in every cycle. A frame is a start byte, a command, a length, that many
// payload bytes, an XOR checksum over command, length and payload, and an end
// byte. A frame whose end byte and checksum match gives one acknowledge beat
// on the rsp channel in the cycle after its end byte is taken; a bad frame or
// an oversized length gives nothing. The acknowledge sits in an output
// register, so bytes other than an end byte keep flowing while it waits.
// Only an end byte that arrives while an earlier acknowledge is still stalled
// is held back. The csr port writes the seven byte registers, one per cycle;
// the user must write them only while the block is idle (not enforced). Reset
// is synchronous: it restores the register defaults, returns the parser to
// hunting for a start byte and empties the output register.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module framed_command_receiver #(
   parameter int unsigned BUFFER_SIZE = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   fcr_req_if.sink                        req,
   fcr_rsp_if.source                      rsp,
   input  logic                           csr_we,
   input  logic [fcr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                     csr_wdata
);
   import fcr_pkg::*;

   localparam int unsigned LEN_MAX = BUFFER_SIZE - FRAME_OVERHEAD;
   localparam int unsigned LEN_W   = $clog2(LEN_MAX + 1);

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_CMD,
      ST_LEN,
      ST_PAYLOAD,
      ST_CHECK,
      ST_END
   } state_type;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [LEN_W-1:0] count_ff, count_in;
   byte_type         command_ff, command_in;
   byte_type         xor_ff, xor_in;
   byte_type         check_ff, check_in;
   byte_type         payload_ff [TIME_SYNC_LEN];

   byte_type start_byte_ff, end_byte_ff, code_time_ff, code_page_ff;
   byte_type code_steps_ff, code_status_ff, page_count_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   byte_type       ack_command_ff;
   ack_status_type ack_status_ff, ack_status_in;
   event_kind_type event_kind_ff, event_kind_in;
   byte_type       hour_ff, minute_ff, second_ff, month_ff, day_ff, weekday_ff;
   byte_type       hour_in, minute_in, second_in, month_in, day_in, weekday_in;
   year_type       year_ff, year_in;
   byte_type       page_ff, page_in;

   logic accept;
   logic good_frame;
   logic load_rsp;
   logic store_payload;

   assign req.ready = !(state_ff == ST_END && rsp_valid_ff && !rsp.ready);
   assign accept    = req.valid && req.ready;

   assign good_frame    = (req.rx_byte == end_byte_ff) && (xor_ff == check_ff);
   assign load_rsp      = accept && state_ff == ST_END && good_frame;
   assign store_payload = accept && state_ff == ST_PAYLOAD &&
                          8'(count_ff) < 8'(TIME_SYNC_LEN);

   always_comb begin
      state_in   = state_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      command_in = command_ff;
      xor_in     = xor_ff;
      check_in   = check_ff;
      if (accept) begin
         unique case (state_ff)
            ST_HUNT: begin
               if (req.rx_byte == start_byte_ff) begin
                  state_in = ST_CMD;
               end
            end
            ST_CMD: begin
               command_in = req.rx_byte;
               xor_in     = req.rx_byte;
               state_in   = ST_LEN;
            end
            ST_LEN: begin
               if ({1'b0, req.rx_byte} > 9'(LEN_MAX)) begin
                  state_in  = ST_HUNT;
                  length_in = '0;
               end else begin
                  length_in = LEN_W'(req.rx_byte);
                  xor_in    = xor_ff ^ req.rx_byte;
                  count_in  = '0;
                  state_in  = (req.rx_byte == 8'd0) ? ST_CHECK : ST_PAYLOAD;
               end
            end
            ST_PAYLOAD: begin
               xor_in   = xor_ff ^ req.rx_byte;
               count_in = count_ff + LEN_W'(1);
               if (count_ff + LEN_W'(1) == length_ff) begin
                  state_in = ST_CHECK;
               end
            end
            ST_CHECK: begin
               check_in = req.rx_byte;
               state_in = ST_END;
            end
            ST_END: begin
               state_in  = ST_HUNT;
               length_in = '0;
            end
            default: begin
               state_in = ST_HUNT;
            end
         endcase
      end
   end

   always_comb begin
      ack_status_in = ACK_UNSUPPORTED;
      event_kind_in = EV_NONE;
      hour_in       = '0;
      minute_in     = '0;
      second_in     = '0;
      year_in       = '0;
      month_in      = '0;
      day_in        = '0;
      weekday_in    = '0;
      page_in       = '0;
      if (command_ff == code_time_ff) begin
         if (8'(length_ff) != 8'(TIME_SYNC_LEN)) begin
            ack_status_in = ACK_BAD_LENGTH;
         end else begin
            ack_status_in = ACK_OK;
            event_kind_in = EV_TIME_SYNC;
            hour_in       = payload_ff[0];
            minute_in     = payload_ff[1];
            second_in     = payload_ff[2];
            year_in       = 12'(YEAR_BASE) + {4'b0000, payload_ff[3]};
            month_in      = payload_ff[4];
            day_in        = payload_ff[5];
            weekday_in    = payload_ff[6];
         end
      end else if (command_ff == code_page_ff) begin
         if (8'(length_ff) != 8'd1) begin
            ack_status_in = ACK_BAD_LENGTH;
         end else if (payload_ff[0] >= page_count_ff) begin
            ack_status_in = ACK_BAD_VALUE;
         end else begin
            ack_status_in = ACK_OK;
            event_kind_in = EV_SET_PAGE;
            page_in       = payload_ff[0];
         end
      end else if (command_ff == code_steps_ff) begin
         if (length_ff != '0) begin
            ack_status_in = ACK_BAD_LENGTH;
         end else begin
            ack_status_in = ACK_OK;
            event_kind_in = EV_RESET_STEPS;
         end
      end else if (command_ff == code_status_ff) begin
         if (length_ff != '0) begin
            ack_status_in = ACK_BAD_LENGTH;
         end else begin
            ack_status_in = ACK_OK;
            event_kind_in = EV_REQUEST_STATUS;
         end
      end
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_HUNT;
         length_ff      <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         start_byte_ff  <= 8'd2;
         end_byte_ff    <= 8'd3;
         code_time_ff   <= 8'd1;
         code_page_ff   <= 8'd2;
         code_steps_ff  <= 8'd3;
         code_status_ff <= 8'd4;
         page_count_ff  <= 8'd4;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_START_BYTE:          start_byte_ff  <= csr_wdata;
               CSR_END_BYTE:            end_byte_ff    <= csr_wdata;
               CSR_CODE_TIME_SYNC:      code_time_ff   <= csr_wdata;
               CSR_CODE_SET_PAGE:       code_page_ff   <= csr_wdata;
               CSR_CODE_RESET_STEPS:    code_steps_ff  <= csr_wdata;
               CSR_CODE_REQUEST_STATUS: code_status_ff <= csr_wdata;
               CSR_PAGE_COUNT:          page_count_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      command_ff <= command_in;
      xor_ff     <= xor_in;
      check_ff   <= check_in;
      if (store_payload) begin
         payload_ff[3'(count_ff)] <= req.rx_byte;
      end
      if (load_rsp) begin
         ack_command_ff <= command_ff;
         ack_status_ff  <= ack_status_in;
         event_kind_ff  <= event_kind_in;
         hour_ff        <= hour_in;
         minute_ff      <= minute_in;
         second_ff      <= second_in;
         year_ff        <= year_in;
         month_ff       <= month_in;
         day_ff         <= day_in;
         weekday_ff     <= weekday_in;
         page_ff        <= page_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.ack_command = ack_command_ff;
   assign rsp.ack_status  = ack_status_ff;
   assign rsp.event_kind  = event_kind_ff;
   assign rsp.hour        = hour_ff;
   assign rsp.minute      = minute_ff;
   assign rsp.second      = second_ff;
   assign rsp.year        = year_ff;
   assign rsp.month       = month_ff;
   assign rsp.day         = day_ff;
   assign rsp.weekday     = weekday_ff;
   assign rsp.page        = page_ff;

   `ASSERT_SAME(a_end_held_when_blocked, clock, reset,
      state_ff == ST_END && rsp_valid_ff && !rsp.ready, !req.ready)
   `ASSERT_NEXT(a_load_sets_valid, clock, reset, load_rsp, rsp_valid_ff)
   `ASSERT_SAME(a_ok_has_event, clock, reset,
      rsp_valid_ff && ack_status_ff == ACK_OK, event_kind_ff != EV_NONE)
   `ASSERT_SAME(a_time_fields_zero, clock, reset,
      rsp_valid_ff && event_kind_ff != EV_TIME_SYNC, year_ff == '0 && hour_ff == '0)
   `ASSERT_NEXT(a_no_result_without_end, clock, reset,
      !load_rsp && !rsp_valid_ff, !rsp_valid_ff)

endmodule
